FILE: rtl/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter unit.
package psu_pkg;

    // Line store geometry: widest row times four bytes per pixel
    localparam int MAX_WIDTH   = 2048;
    localparam int STORE_DEPTH = MAX_WIDTH * 4;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int WIDTH_W  = 12;
    localparam int CHAN_W   = 3;
    localparam int HEIGHT_W = 16;
    localparam int POS_W    = 14;
    localparam int CFG_W    = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_CHANNEL = 2'd1;
    localparam logic [1:0] CFG_HEIGHT  = 2'd2;

    // Filter types carried by the row's leading byte
    typedef enum logic [2:0] {
        FILT_NONE    = 3'd0,
        FILT_SUB     = 3'd1,
        FILT_UP      = 3'd2,
        FILT_AVERAGE = 3'd3,
        FILT_PAETH   = 3'd4
    } filter_t;

    localparam logic [BYTE_W-1:0] FILT_MAX = 8'd4;

    // What an entry of the read stage does when it advances
    typedef enum logic [1:0] {
        KIND_FILTER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // Paeth predictor: pick the neighbor closest to a + b - c
    function automatic logic [BYTE_W-1:0] paeth_pick(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [BYTE_W+2:0] pa;
        logic signed [BYTE_W+2:0] pb;
        logic signed [BYTE_W+2:0] pc;
        logic signed [BYTE_W+2:0] ea;
        logic signed [BYTE_W+2:0] eb;
        logic signed [BYTE_W+2:0] ec;
        logic [BYTE_W-1:0]        pick;
        pa = $signed({3'b000, b}) - $signed({3'b000, c});
        pb = $signed({3'b000, a}) - $signed({3'b000, c});
        pc = pa + pb;
        ea = (pa < 0) ? -pa : pa;
        eb = (pb < 0) ? -pb : pb;
        ec = (pc < 0) ? -pc : pc;
        if (ea <= eb && ea <= ec)
        begin
            pick = a;
        end
        else if (eb <= ec)
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

FILE: rtl/png_scanline_unfilter_unit.sv
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth) for 8-bit RGB/RGBA.
//
//   channel   direction  tdata / tuser                          tlast
//   s_axis    in         tdata: stream_byte; tuser: image_start  -
//   m_axis    out        tdata: pixel_byte;                      row_last
//                        tuser: image_last, bad_filter
//   cfg       in         write enable, index, data              -
//
// One byte per cycle sustained while the output is not stalled. A result reaches m_axis
// through the read stage, where its word waits while the line store answers, and is then
// reconstructed into the output register. The left neighbor lies three or four bytes
// back and is always written before it is needed.
// Reset clears all control state; the line store needs no clearing pass.
// An output stall holds the read stage and with it the input; filter words still drain.
module png_scanline_unfilter_unit
    import psu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] stream_byte
    input  logic                s_axis_tuser,   // [0] image_start
    // output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [BYTE_W-1:0]   m_axis_tdata,   // [7:0] pixel_byte
    output logic                m_axis_tlast,   // row_last
    output logic [1:0]          m_axis_tuser,   // [0] image_last, [1] bad_filter
    // configuration
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    // Configuration registers
    logic [WIDTH_W-1:0]  width_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // Row tracking state
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [1:0]          mod3_reg,   mod3_next;
    logic [HEIGHT_W-1:0] row_reg,    row_next;
    logic                expect_reg, expect_next;
    logic                drop_reg,   drop_next;
    filter_t             filt_reg,   filt_next;

    // Read stage
    logic                p_valid_reg, p_valid_next;
    kind_t               p_kind_reg;
    logic [BYTE_W-1:0]   p_byte_reg;
    filter_t             p_filt_reg;
    logic [1:0]          p_lane_reg;
    logic [ADDR_W-1:0]   p_addr_reg;
    logic                p_first_reg;
    logic                p_rlast_reg;
    logic                p_ilast_reg;

    // Output register
    logic                o_valid_reg, o_valid_next;
    logic [BYTE_W-1:0]   o_byte_reg;
    logic                o_rlast_reg;
    logic                o_ilast_reg;
    logic                o_bad_reg;

    // Neighbor lanes
    logic [BYTE_W-1:0]   left_reg  [4];
    logic [BYTE_W-1:0]   upper_reg [4];

    logic [BYTE_W-1:0]   rd_data;
    logic [WIDTH_W-1:0]  eff_width;
    logic                ch4;
    logic [POS_W-1:0]    row_len;

    logic                in_acc;
    logic                out_acc;
    logic                p_adv;

    // Accept-side decode
    logic                st_start;
    logic [HEIGHT_W-1:0] row_e;
    logic                drop_e;
    logic                expect_e;
    logic [POS_W-1:0]    pos_e;
    logic [1:0]          mod3_e;
    logic                ignore;
    logic                enter;
    kind_t               enter_kind;
    logic [POS_W-1:0]    pos_inc;
    logic                row_end;
    logic                img_end;
    logic [1:0]          lane;
    logic                rd_en;

    // Reconstruction
    logic [BYTE_W-1:0]   nb_a;
    logic [BYTE_W-1:0]   nb_b;
    logic [BYTE_W-1:0]   nb_c;
    logic [BYTE_W:0]     avg_sum;
    logic [BYTE_W-1:0]   pred;
    logic [BYTE_W-1:0]   recon;

    // Effective row geometry
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = WIDTH_W'(1);
        end
        else if ({1'b0, width_reg} > (WIDTH_W+1)'(MAX_WIDTH))
        begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    assign ch4     = (chan_reg >= CHAN_W'(4));
    assign row_len = ch4 ? {eff_width, 2'b00}
                         : POS_W'({eff_width, 1'b0}) + POS_W'(eff_width);

    // Handshakes
    assign p_adv         = p_valid_reg && ((p_kind_reg == KIND_FILTER) ||
                                           !o_valid_reg || m_axis_tready);
    assign s_axis_tready = !p_valid_reg || p_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = o_valid_reg && m_axis_tready;

    // Image start overrides the row tracking state for this word
    always_comb
    begin
        st_start = s_axis_tuser;
        row_e    = st_start ? '0   : row_reg;
        drop_e   = st_start ? 1'b0 : drop_reg;
        expect_e = st_start ? 1'b1 : expect_reg;
        pos_e    = st_start ? '0   : pos_reg;
        mod3_e   = st_start ? '0   : mod3_reg;
        ignore   = drop_e || (row_e >= height_reg);
        pos_inc  = pos_e + POS_W'(1);
        row_end  = (pos_inc >= row_len) || (pos_inc == '0);
        img_end  = ({1'b0, row_e} + (HEIGHT_W+1)'(1)) == {1'b0, height_reg};
        lane     = ch4 ? pos_e[1:0] : mod3_e;
    end

    // Next row tracking state
    always_comb
    begin
        pos_next    = pos_reg;
        mod3_next   = mod3_reg;
        row_next    = row_reg;
        expect_next = expect_reg;
        drop_next   = drop_reg;
        filt_next   = filt_reg;
        enter       = 1'b0;
        enter_kind  = KIND_DATA;
        rd_en       = 1'b0;
        if (in_acc)
        begin
            pos_next    = pos_e;
            mod3_next   = mod3_e;
            row_next    = row_e;
            expect_next = expect_e;
            drop_next   = drop_e;
            if (!ignore)
            begin
                enter = 1'b1;
                if (expect_e)
                begin
                    if (s_axis_tdata > FILT_MAX)
                    begin
                        // drop the rest of the image
                        drop_next  = 1'b1;
                        enter_kind = KIND_ERROR;
                    end
                    else
                    begin
                        filt_next   = filter_t'(s_axis_tdata[2:0]);
                        pos_next    = '0;
                        mod3_next   = '0;
                        expect_next = 1'b0;
                        enter_kind  = KIND_FILTER;
                    end
                end
                else
                begin
                    enter_kind = KIND_DATA;
                    rd_en      = 1'b1;
                    if (row_end)
                    begin
                        row_next    = row_e + HEIGHT_W'(1);
                        expect_next = 1'b1;
                        pos_next    = '0;
                        mod3_next   = '0;
                    end
                    else
                    begin
                        pos_next  = pos_inc;
                        mod3_next = (mod3_e == 2'd2) ? 2'd0 : mod3_e + 2'd1;
                    end
                end
            end
        end
    end

    // Stage valids
    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (enter)
        begin
            p_valid_next = 1'b1;
        end
        else if (p_adv)
        begin
            p_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (p_adv && (p_kind_reg != KIND_FILTER))
        begin
            o_valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            o_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_W'(1);
            chan_reg    <= CHAN_W'(3);
            height_reg  <= HEIGHT_W'(1);
            pos_reg     <= '0;
            mod3_reg    <= '0;
            row_reg     <= '0;
            expect_reg  <= 1'b1;
            drop_reg    <= 1'b0;
            filt_reg    <= FILT_NONE;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH:   width_reg  <= cfg_data[WIDTH_W-1:0];
                    CFG_CHANNEL: chan_reg   <= cfg_data[CHAN_W-1:0];
                    CFG_HEIGHT:  height_reg <= cfg_data[HEIGHT_W-1:0];
                    default:     ;
                endcase
            end
            pos_reg     <= pos_next;
            mod3_reg    <= mod3_next;
            row_reg     <= row_next;
            expect_reg  <= expect_next;
            drop_reg    <= drop_next;
            filt_reg    <= filt_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Load the read stage
    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            p_kind_reg  <= enter_kind;
            p_byte_reg  <= s_axis_tdata;
            p_filt_reg  <= filt_reg;
            p_lane_reg  <= lane;
            p_addr_reg  <= pos_e[ADDR_W-1:0];
            p_first_reg <= (row_e == '0);
            p_rlast_reg <= row_end;
            p_ilast_reg <= row_end && img_end;
        end
    end

    // Line store: read at accept, write back as the byte leaves the read stage
    psu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (p_adv && (p_kind_reg == KIND_DATA)),
        .waddr (p_addr_reg),
        .wdata (recon),
        .re    (rd_en),
        .raddr (pos_e[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // Predict and reconstruct
    always_comb
    begin
        nb_a    = left_reg[p_lane_reg];
        nb_c    = upper_reg[p_lane_reg];
        nb_b    = p_first_reg ? '0 : rd_data;
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        case (p_filt_reg)
            FILT_SUB:     pred = nb_a;
            FILT_UP:      pred = nb_b;
            FILT_AVERAGE: pred = avg_sum[BYTE_W:1];
            FILT_PAETH:   pred = paeth_pick(nb_a, nb_b, nb_c);
            default:      pred = '0;
        endcase
        recon = p_byte_reg + pred;
    end

    // Neighbor lanes: clear on a filter word, update on a data word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                left_reg[i]  <= '0;
                upper_reg[i] <= '0;
            end
        end
        else if (p_adv)
        begin
            if (p_kind_reg == KIND_FILTER)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    left_reg[i]  <= '0;
                    upper_reg[i] <= '0;
                end
            end
            else if (p_kind_reg == KIND_DATA)
            begin
                left_reg[p_lane_reg]  <= recon;
                upper_reg[p_lane_reg] <= nb_b;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (p_adv && (p_kind_reg != KIND_FILTER))
        begin
            if (p_kind_reg == KIND_ERROR)
            begin
                o_byte_reg  <= '0;
                o_rlast_reg <= 1'b0;
                o_ilast_reg <= 1'b0;
                o_bad_reg   <= 1'b1;
            end
            else
            begin
                o_byte_reg  <= recon;
                o_rlast_reg <= p_rlast_reg;
                o_ilast_reg <= p_ilast_reg;
                o_bad_reg   <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_byte_reg;
    assign m_axis_tlast  = o_rlast_reg;
    assign m_axis_tuser  = {o_bad_reg, o_ilast_reg};

endmodule

FILE: rtl/psu_ram.sv
// Generic simple dual-port RAM with registered, enabled read.
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, holds its data while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: tb/png_scanline_unfilter_unit_test.sv
// Self-checking testbench for the PNG scanline unfilter unit.
`timescale 1ns / 1ps

module png_scanline_unfilter_unit_test;
    import psu_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_BYTES = 1650;

    // One output word as the block should present it
    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              row_end;
        logic              image_end;
        logic              bad;
    } out_word_t;

    // Where the expectation of an input word comes from
    typedef enum logic [1:0] {
        SRC_MODEL = 2'd0,
        SRC_NONE  = 2'd1,
        SRC_TYPED = 2'd2
    } src_t;

    typedef struct packed {
        src_t      src;
        out_word_t word;
    } mark_t;

    typedef enum logic [1:0] {
        STEP_BYTE = 2'd0,
        STEP_REG  = 2'd1
    } step_kind_t;

    typedef struct packed {
        step_kind_t      kind;
        logic [1:0]      reg_idx;
        logic [CFG_W-1:0] val;
        logic            start;
        src_t            src;
        out_word_t       word;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata = '0;  // [7:0] stream_byte
    logic                s_axis_tuser = 1'b0; // [0] image_start
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]   m_axis_tdata;       // [7:0] pixel_byte
    logic                m_axis_tlast;
    logic [1:0]          m_axis_tuser;       // [0] image_last, [1] bad_filter
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = CFG_WIDTH;
    logic [CFG_W-1:0]    cfg_data = '0;

    png_scanline_unfilter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // Shadow of the block: configuration and reconstruction state
    logic [WIDTH_W-1:0]  cfg_width = 12'd1;
    logic [CHAN_W-1:0]   cfg_chan = 3'd3;
    logic [HEIGHT_W-1:0] cfg_height = 16'd1;
    bit [BYTE_W-1:0]     line_mem [STORE_DEPTH];
    bit [BYTE_W-1:0]     left_px [4];
    bit [BYTE_W-1:0]     upleft_px [4];
    filter_t             row_filter = FILT_NONE;
    logic [POS_W-1:0]    pos = '0;
    int                  rows_done = 0;
    bit                  want_filter = 1'b1;
    bit                  dropping = 1'b0;

    out_word_t expected_pixels [$];
    mark_t     word_marks [$];
    int        mismatch_count = 0;
    int        taken_bytes = 0;
    int        quiet_cycles = 0;
    bit        sender_gaps = 1'b1;
    bit        receiver_stalls = 1'b1;
    int        stall_left = 0;
    mark_t     in_mark;
    logic      in_made;
    out_word_t in_word;
    out_word_t want;

    // Directed stimulus; typed results only where obvious
    step_t steps [25] = '{
        // reset setup: one RGB pixel per row, one row
        '{STEP_BYTE, 2'd0, 16'h0000, 1'b1, SRC_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 2'd0, 16'h00FF, 1'b0, SRC_TYPED, '{8'hFF, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 2'd0, 16'h0000, 1'b0, SRC_TYPED, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 2'd0, 16'h0080, 1'b0, SRC_TYPED, '{8'h80, 1'b1, 1'b1, 1'b0}},
        // row past the image height is ignored
        '{STEP_BYTE, 2'd0, 16'h003C, 1'b0, SRC_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
        // bad filter type, then the dropped remainder
        '{STEP_BYTE, 2'd0, 16'h00FF, 1'b1, SRC_TYPED, '{8'h00, 1'b0, 1'b0, 1'b1}},
        '{STEP_BYTE, 2'd0, 16'h0001, 1'b0, SRC_NONE,  '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{STEP_REG,  CFG_HEIGHT, 16'd4, 1'b0, SRC_NONE, '{8'h00, 1'b0, 1'b0, 1'b0}},
        // four rows: Sub, Up, Average, Paeth
        '{STEP_BYTE, 2'd0, 16'(FILT_SUB), 1'b1, SRC_NONE, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 2'd0, 16'h0010, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'h00F0, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'h007F, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'(FILT_UP), 1'b0, SRC_NONE, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 2'd0, 16'h00F0, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'h0020, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'h0081, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'(FILT_AVERAGE), 1'b0, SRC_NONE, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 2'd0, 16'h00FF, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'h0001, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'h0055, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'(FILT_PAETH), 1'b0, SRC_NONE, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 2'd0, 16'h0003, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'h00FE, 1'b0, SRC_MODEL, '0},
        '{STEP_BYTE, 2'd0, 16'h00AA, 1'b0, SRC_MODEL, '0},
        // filter type just above the highest one
        '{STEP_BYTE, 2'd0, 16'h0005, 1'b1, SRC_TYPED, '{8'h00, 1'b0, 1'b0, 1'b1}}
    };

    function automatic int lane_count();
        return (cfg_chan >= 3'd4) ? 4 : 3;
    endfunction

    function automatic int line_len();
        int w;
        w = (cfg_width == '0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
        return w * lane_count();
    endfunction

    function automatic int paeth_choice(input int a, input int b, input int c);
        int est;
        int da;
        int db;
        int dc;
        est = a + b - c;
        da = (est > a) ? est - a : a - est;
        db = (est > b) ? est - b : b - est;
        dc = (est > c) ? est - c : c - est;
        if (da <= db && da <= dc)
        begin
            return a;
        end
        return (db <= dc) ? b : c;
    endfunction

    // Advance the shadow by one accepted stream word
    task automatic unfilter_step(input logic [BYTE_W-1:0] sb, input logic start,
                                 output logic made, output out_word_t w);
        int lane;
        int a;
        int b;
        int c;
        int pred;
        logic [BYTE_W-1:0] x;
        made = 1'b0;
        w = '0;
        if (start)
        begin
            rows_done = 0;
            dropping = 1'b0;
            want_filter = 1'b1;
            pos = '0;
        end
        if (dropping || rows_done >= cfg_height)
        begin
            return;
        end
        taken_bytes++;
        if (want_filter)
        begin
            if (sb > FILT_MAX)
            begin
                dropping = 1'b1;
                w.bad = 1'b1;
                made = 1'b1;
                return;
            end
            row_filter = filter_t'(sb[2:0]);
            pos = '0;
            want_filter = 1'b0;
            foreach (left_px[k])
            begin
                left_px[k] = '0;
                upleft_px[k] = '0;
            end
            return;
        end
        lane = int'(pos) % lane_count();
        a = left_px[lane];
        b = (rows_done != 0) ? int'(line_mem[pos]) : 0;
        c = upleft_px[lane];
        case (row_filter)
            FILT_SUB:     pred = a;
            FILT_UP:      pred = b;
            FILT_AVERAGE: pred = (a + b) >> 1;
            FILT_PAETH:   pred = paeth_choice(a, b, c);
            default:      pred = 0;
        endcase
        x = 8'(int'(sb) + pred);
        line_mem[pos] = x;
        upleft_px[lane] = 8'(b);
        left_px[lane] = x;
        pos = pos + 1'b1;
        w.pixel = x;
        made = 1'b1;
        if (pos >= line_len() || pos == '0)
        begin
            w.row_end = 1'b1;
            w.image_end = (rows_done + 1 == int'(cfg_height));
            rows_done++;
            want_filter = 1'b1;
            pos = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Present one stream word and hold it until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start,
                             input src_t src, input out_word_t w);
        if (sender_gaps && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        word_marks.push_back('{src, w});
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Stop sending, drain every expected word, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_WIDTH)
        begin
            cfg_width = val[WIDTH_W-1:0];
        end
        else if (idx == CFG_CHANNEL)
        begin
            cfg_chan = val[CHAN_W-1:0];
        end
        else if (idx == CFG_HEIGHT)
        begin
            cfg_height = val[HEIGHT_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] c,
                              input logic [CFG_W-1:0] h, input logic [2:0] mask);
        if (mask[0])
        begin
            write_reg(CFG_WIDTH, w);
        end
        if (mask[1])
        begin
            write_reg(CFG_CHANNEL, c);
        end
        if (mask[2])
        begin
            write_reg(CFG_HEIGHT, h);
        end
        cfg_we <= 1'b0;
    endtask

    // Send an image of filter bytes and rows; noisy images may break off
    task automatic send_image(input int rows, input bit with_start, input bit clean);
        int r;
        int k;
        int len;
        logic [BYTE_W-1:0] f;
        for (r = 0; r < rows; r++)
        begin
            len = line_len();
            if (clean || $urandom_range(0, 39) != 0)
            begin
                f = 8'($urandom_range(0, FILT_MAX));
            end
            else
            begin
                f = 8'($urandom_range(FILT_MAX + 1, 255));
            end
            send_byte(f, with_start && r == 0, SRC_MODEL, '0);
            if (f > FILT_MAX)
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, SRC_MODEL, '0);
                return;
            end
            for (k = 0; k < len; k++)
            begin
                if (!clean && $urandom_range(0, 299) == 0)
                begin
                    return;
                end
                send_byte(8'($urandom), 1'b0, SRC_MODEL, '0);
            end
        end
    endtask

    // Predict on every accepted stream word
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            in_mark = word_marks.pop_front();
            unfilter_step(s_axis_tdata, s_axis_tuser, in_made, in_word);
            if (in_mark.src == SRC_TYPED)
            begin
                expected_pixels.push_back(in_mark.word);
            end
            else if (in_mark.src == SRC_MODEL && in_made)
            begin
                expected_pixels.push_back(in_word);
            end
        end
    end

    // Check each output word, then plan the next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("output word %02h with nothing expected",
                                          m_axis_tdata));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want.pixel)
                begin
                    report_mismatch($sformatf("pixel_byte %02h, want %02h",
                                              m_axis_tdata, want.pixel));
                end
                if (m_axis_tlast !== want.row_end)
                begin
                    report_mismatch($sformatf("row_last %b, want %b",
                                              m_axis_tlast, want.row_end));
                end
                if (m_axis_tuser[0] !== want.image_end)
                begin
                    report_mismatch($sformatf("image_last %b, want %b",
                                              m_axis_tuser[0], want.image_end));
                end
                if (m_axis_tuser[1] !== want.bad)
                begin
                    report_mismatch($sformatf("bad_filter %b, want %b",
                                              m_axis_tuser[1], want.bad));
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (receiver_stalls && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("png_scanline_unfilter_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        int i;
        int img;
        int n_img;
        int rows;
        int pick;
        int goal;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] c_val;
        logic [CFG_W-1:0] h_val;
        logic [2:0] mask;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (i = 0; i < $size(steps); i++)
        begin
            if (steps[i].kind == STEP_REG)
            begin
                wait_idle();
                write_reg(steps[i].reg_idx, steps[i].val);
                cfg_we <= 1'b0;
            end
            else
            begin
                send_byte(steps[i].val[7:0], steps[i].start, steps[i].src, steps[i].word);
            end
        end

        // Fill the line store over the longest row the random part can use
        wait_idle();
        set_config(16'd40, 16'd4, 16'd1, 3'b111);
        send_image(1, 1'b1, 1'b1);

        // Random phases with changing setup
        goal = taken_bytes + RANDOM_BYTES;
        mask = 3'b111;
        while (taken_bytes < goal)
        begin
            wait_idle();
            pick = $urandom_range(0, 15);
            w_val = (pick == 0) ? 16'd0 :
                    (pick == 1) ? 16'($urandom_range(9, 40)) : 16'($urandom_range(1, 8));
            c_val = 16'($urandom_range(0, 7));
            pick = $urandom_range(0, 9);
            h_val = (pick == 0) ? 16'd0 :
                    (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 5));
            set_config(w_val, c_val, h_val, mask);
            mask = 3'($urandom_range(0, 7));
            sender_gaps = (taken_bytes + 300 < goal) && $urandom_range(0, 3) != 0;
            receiver_stalls = (taken_bytes + 300 < goal) && $urandom_range(0, 3) != 0;
            n_img = $urandom_range(1, 4);
            for (img = 0; img < n_img; img++)
            begin
                rows = (cfg_height == '0) ? 1 : ((cfg_height > 16'd4) ? 3 : int'(cfg_height));
                if ($urandom_range(0, 3) == 0)
                begin
                    rows++;
                end
                send_image(rows, img > 0 || $urandom_range(0, 7) != 0, 1'b0);
                // stray words between images
                if ($urandom_range(0, 5) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom), 1'($urandom), SRC_MODEL, '0);
                end
            end
        end

        wait_idle();
        receiver_stalls = 1'b0;
        repeat (8) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected words never came", expected_pixels.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("png_scanline_unfilter_unit_test: clean");
        end
        else
        begin
            $display("png_scanline_unfilter_unit_test: errors");
        end
        $finish;
    end

endmodule
